FILE: rtl/ffac_pkg.sv
// Shared types and constants for the fully associative FIFO-replacement cache.
// No dependencies; used by ffac_ctrl, ffac_dp and the top level.
`default_nettype none

package ffac_pkg;

  localparam int ADDR_W  = 64;
  localparam int CNT_W   = 32;
  localparam int SHIFT_W = 4;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic start;   // latch tag, arm the scan
    logic scan;    // issue one tag read, compare the previous one
    logic commit;  // update state and load the result register
    logic hit;     // result of the lookup, valid with commit
  } ffac_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic match;   // compared tag equals the request tag
    logic last;    // final occupied line is being compared
    logic empty;   // no occupied lines
  } ffac_status_t;

endpackage

`default_nettype wire

FILE: rtl/ffac_ctrl.sv
// Lookup sequencer for the fully associative cache: accept, scan, commit.
// Depends on ffac_pkg for the command and status structs.
`default_nettype none

module ffac_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  input  wire ffac_pkg::ffac_status_t status,
  output ffac_pkg::ffac_cmd_t        cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   hit_r, hit_nxt;
  logic   accept;
  logic   commit;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && (state_r == ST_IDLE);
  assign commit    = (state_r == ST_UPDATE) && (!out_valid_r || !out_stall);

  assign cmd.start  = accept;
  assign cmd.scan   = (state_r == ST_SCAN);
  assign cmd.commit = commit;
  assign cmd.hit    = hit_r;

  always_comb begin
    state_nxt     = state_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          hit_nxt = 1'b0;
          // empty cache: skip straight to a miss
          state_nxt = status.empty ? ST_UPDATE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.match) begin
          hit_nxt   = 1'b1;
          state_nxt = ST_UPDATE;
        end else if (status.last) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (commit) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      hit_r       <= hit_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ffac_dp.sv
// Datapath for the fully associative cache: tag memory, queue pointers,
// scan counter, running totals and result register. Depends on ffac_pkg.
`default_nettype none

module ffac_dp #(
  parameter int WAYS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  input  wire logic [ffac_pkg::SHIFT_W-1:0]    cfg_data,
  input  wire logic [ffac_pkg::ADDR_W-1:0]     in_address,
  input  wire ffac_pkg::ffac_cmd_t             cmd,
  output ffac_pkg::ffac_status_t               status,
  output logic                                 out_hit,
  output logic                                 out_evicted,
  output logic [ffac_pkg::CNT_W-1:0]           out_hit_total,
  output logic [ffac_pkg::CNT_W-1:0]           out_miss_total,
  output logic [ffac_pkg::CNT_W-1:0]           out_eviction_total
);

  localparam int IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int USE_W = $clog2(WAYS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WAYS - 1);
  localparam logic [USE_W-1:0] FULL_CNT = USE_W'(WAYS);

  logic [ffac_pkg::ADDR_W-1:0]  mem [WAYS];
  logic [ffac_pkg::ADDR_W-1:0]  rd_data_r;
  logic [ffac_pkg::ADDR_W-1:0]  tag_r;
  logic [ffac_pkg::SHIFT_W-1:0] shift_r;
  logic [IDX_W-1:0]             ptr_r;
  logic [IDX_W-1:0]             oldest_r;
  logic [IDX_W-1:0]             tail_r;
  logic [USE_W-1:0]             used_r;
  logic [USE_W-1:0]             cnt_r;
  logic                         cmp_v_r;
  logic [ffac_pkg::CNT_W-1:0]   hits_r, misses_r, evicts_r;
  logic [ffac_pkg::CNT_W-1:0]   hits_nxt, misses_nxt, evicts_nxt;
  logic                         full;
  logic                         evict;
  logic                         mem_we;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
    idx_inc = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  assign full   = (used_r == FULL_CNT);
  assign evict  = cmd.commit && !cmd.hit && full;
  assign mem_we = cmd.commit && !cmd.hit;

  assign status.match = cmp_v_r && (rd_data_r == tag_r);
  assign status.last  = cmp_v_r && (cnt_r == used_r);
  assign status.empty = (used_r == '0);

  assign hits_nxt   = cmd.hit ? hits_r + 1'b1 : hits_r;
  assign misses_nxt = cmd.hit ? misses_r : misses_r + 1'b1;
  assign evicts_nxt = evict ? evicts_r + 1'b1 : evicts_r;

  // Tag memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail_r] <= tag_r;
    end
    rd_data_r <= mem[ptr_r];
  end

  // Request tag and scan pointer
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      tag_r <= in_address >> shift_r;
      ptr_r <= oldest_r;
    end else if (cmd.scan && (cnt_r != used_r)) begin
      ptr_r <= idx_inc(ptr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r  <= ffac_pkg::SHIFT_RESET;
      cnt_r    <= '0;
      cmp_v_r  <= 1'b0;
      used_r   <= '0;
      oldest_r <= '0;
      tail_r   <= '0;
      hits_r   <= '0;
      misses_r <= '0;
      evicts_r <= '0;
    end else begin
      if (cfg_valid) begin
        shift_r <= cfg_data;
      end
      if (cmd.start) begin
        cnt_r   <= '0;
        cmp_v_r <= 1'b0;
      end else if (cmd.scan) begin
        // issue the next read while lines remain, compare the last one read
        if (cnt_r != used_r) begin
          cnt_r   <= cnt_r + 1'b1;
          cmp_v_r <= 1'b1;
        end else begin
          cmp_v_r <= 1'b0;
        end
      end
      if (cmd.commit) begin
        hits_r   <= hits_nxt;
        misses_r <= misses_nxt;
        evicts_r <= evicts_nxt;
        if (!cmd.hit) begin
          tail_r <= idx_inc(tail_r);
          // full: the new tag takes the oldest slot, occupancy holds
          if (full) begin
            oldest_r <= idx_inc(oldest_r);
          end else begin
            used_r <= used_r + 1'b1;
          end
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit            <= cmd.hit;
      out_evicted        <= evict;
      out_hit_total      <= hits_nxt;
      out_miss_total     <= misses_nxt;
      out_eviction_total <= evicts_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fifo_fully_associative_cache.sv
// Fully associative cache with FIFO replacement, one address per request.
// A miss scans every occupied line of the tag memory, a hit stops at the
// matching line and an empty cache skips the scan; the scan reads one tag per
// cycle. A new request is taken only once the last result is committed, which
// waits while the output is stalled. Synchronous active-low reset empties the
// queue, clears all counts and sets the address shift to 4. Depends on ffac_pkg.
`default_nettype none

module fifo_fully_associative_cache #(
  parameter int WAYS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [ffac_pkg::SHIFT_W-1:0] cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [ffac_pkg::ADDR_W-1:0]  in_address,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_hit,
  output logic                              out_evicted,
  output logic [ffac_pkg::CNT_W-1:0]        out_hit_total,
  output logic [ffac_pkg::CNT_W-1:0]        out_miss_total,
  output logic [ffac_pkg::CNT_W-1:0]        out_eviction_total
);

  ffac_pkg::ffac_cmd_t    cmd;
  ffac_pkg::ffac_status_t status;

  // configuration is registered and accepted at any time
  assign cfg_ready = 1'b1;

  ffac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  ffac_dp #(
    .WAYS (WAYS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_data           (cfg_data),
    .in_address         (in_address),
    .cmd                (cmd),
    .status             (status),
    .out_hit            (out_hit),
    .out_evicted        (out_evicted),
    .out_hit_total      (out_hit_total),
    .out_miss_total     (out_miss_total),
    .out_eviction_total (out_eviction_total)
  );

endmodule

`default_nettype wire
